FILE: rtl/ramsp_pkg.sv
// Shared types, constants and helpers for the range add/multiply/set/sum core.
// Used by ramsp_modmul and range_add_mul_set_sum_mod_prime_core.
package ramsp_pkg;

    // Field widths
    localparam int OP_W  = 2;
    localparam int IDX_W = 10;
    localparam int VAL_W = 30;
    localparam int LEN_W = 11;

    // Stream bus widths (byte aligned)
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;

    // Modulus and Barrett reduction constants
    localparam logic [VAL_W-1:0] PRIME_V = 30'd1000000007;
    localparam int               RED_W   = 32;   // width of the Barrett remainder
    localparam int               MU_W    = 32;
    localparam int               MU_SH   = 61;   // mu = floor(2^61 / p)
    localparam int               HI_SH   = 29;   // product bits dropped before mu multiply
    localparam logic [MU_W-1:0]  BARRETT_MU = MU_W'((64'd1 << MU_SH) / 64'd1000000007);

    // Latency of the pipelined modular multiplier
    localparam int MUL_LAT = 5;

    // Reset value of the length register
    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    typedef logic [VAL_W-1:0] val_t;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_SET = 2'd2,
        OP_SUM = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    // (a + b) mod p for a, b below 2^30 whose sum is below 2p
    function automatic val_t mod_add(input val_t a, input val_t b);
        logic [VAL_W:0] s;
        logic [VAL_W:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, PRIME_V};
        return (s >= {1'b0, PRIME_V}) ? d[VAL_W-1:0] : s[VAL_W-1:0];
    endfunction

endpackage

FILE: rtl/ramsp_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module ramsp_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ramsp_modmul.sv
// Pipelined modular multiplier, a * b mod p, Barrett reduction.
// Depends on ramsp_pkg.
module ramsp_modmul (
    input  logic            aclk,
    input  ramsp_pkg::val_t a,
    input  ramsp_pkg::val_t b,
    output ramsp_pkg::val_t prod
);
    import ramsp_pkg::*;

    localparam int PW = 2 * VAL_W;
    localparam int HW = PW - HI_SH;

    localparam logic [RED_W-1:0] P1 = RED_W'(PRIME_V);
    localparam logic [RED_W-1:0] P2 = RED_W'({PRIME_V, 1'b0});

    logic [PW-1:0]    p1_reg;
    logic [PW-1:0]    p2_reg;
    val_t             q_reg;
    logic [RED_W-1:0] plo_reg;
    logic [RED_W-1:0] qp_reg;
    logic [RED_W-1:0] r_reg;
    val_t             prod_reg;

    logic [HW-1:0]        hi;
    logic [HW+MU_W-1:0]   qt;
    logic [PW-1:0]        qp_full;
    logic [RED_W-1:0]     r_m1;
    logic [RED_W-1:0]     r_m2;

    assign hi      = p1_reg[PW-1:HI_SH];
    assign qt      = {{MU_W{1'b0}}, hi} * {{HW{1'b0}}, BARRETT_MU};
    assign qp_full = {{VAL_W{1'b0}}, q_reg} * {{VAL_W{1'b0}}, PRIME_V};
    assign r_m1    = r_reg - P1;
    assign r_m2    = r_reg - P2;

    always_ff @(posedge aclk) begin
        // stage 1: full product
        p1_reg  <= {{VAL_W{1'b0}}, a} * {{VAL_W{1'b0}}, b};
        // stage 2: quotient estimate, at most two below the true quotient
        p2_reg  <= p1_reg;
        q_reg   <= qt[MU_W +: VAL_W];
        // stage 3: quotient times modulus, low bits only
        plo_reg <= p2_reg[RED_W-1:0];
        qp_reg  <= qp_full[RED_W-1:0];
        // stage 4: remainder below 3p
        r_reg   <= plo_reg - qp_reg;
        // stage 5: final correction
        if (r_reg >= P2) begin
            prod_reg <= r_m2[VAL_W-1:0];
        end else if (r_reg >= P1) begin
            prod_reg <= r_m1[VAL_W-1:0];
        end else begin
            prod_reg <= r_reg[VAL_W-1:0];
        end
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/range_add_mul_set_sum_mod_prime_core.sv
// Range add / multiply / set / sum over MAX_ENTRIES residues modulo 1000000007.
// Depends on ramsp_pkg, ramsp_ram and ramsp_modmul.
//
// Each transfer on the s_ side names an operation and an inclusive index range;
// the core walks the range through one RAM, reading one element per cycle,
// and a six-stage read/multiply/reduce pipeline writes each result back. The
// core takes no next item until the range has been walked through the single
// RAM read port (one element per cycle) and has passed the RAM read register
// and the five-stage modular multiplier; the core drains that pipeline before
// the next item. Items flagged for an index at or beyond the length in use, and
// empty ranges (first above last), skip the walk and go straight to the result.
// One result transfer per item leaves through an output register, so the next
// item is taken while the result still waits. After reset the core clears the
// whole RAM to zero and takes no item meanwhile; the length register can be
// written at any time the core is idle.
module range_add_mul_set_sum_mod_prime_core #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [9:0] first_index, [19:10] last_index, [49:20] operand_value, [55:50] zero
    input  logic [ramsp_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] opcode
    input  logic [ramsp_pkg::S_TUSER_W-1:0] s_tuser,
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [29:0] range_sum, [31:30] zero
    output logic [ramsp_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] status
    output logic [ramsp_pkg::M_TUSER_W-1:0] m_tuser,
    // length_in_use register
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ramsp_pkg::LEN_W-1:0]     cfg_data
);
    import ramsp_pkg::*;

    localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int XW  = (AW > IDX_W) ? AW : IDX_W;
    localparam int CLW = $clog2(MAX_ENTRIES + 1);
    localparam int LW  = (CLW > LEN_W) ? CLW : LEN_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ENTRIES - 1);
    localparam logic [LW-1:0] MAX_LEN   = LW'(MAX_ENTRIES);

    // ---------------------------------------------------------------
    // Field unpacking
    // ---------------------------------------------------------------
    logic [IDX_W-1:0] in_first;
    logic [IDX_W-1:0] in_last;
    val_t             in_operand;

    assign in_first   = s_tdata[IDX_W-1:0];
    assign in_last    = s_tdata[2*IDX_W-1:IDX_W];
    assign in_operand = s_tdata[2*IDX_W +: VAL_W];

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t           state_reg, state_next;
    logic [AW-1:0]    cur_reg, cur_next;
    logic [LEN_W-1:0] len_reg;
    op_t              op_reg;
    logic [AW-1:0]    hi_reg;
    val_t             v_reg;
    logic             status_reg;
    val_t             acc_reg;
    logic             m_tvalid_reg;
    val_t             m_sum_reg;
    logic             m_status_reg;

    // pipeline side band: valid, address and old element
    logic [MUL_LAT:0] vld_reg;
    logic [AW-1:0]    addr_pipe_reg [MUL_LAT+1];
    val_t             e_pipe_reg    [MUL_LAT];

    // ---------------------------------------------------------------
    // Range check at acceptance
    // ---------------------------------------------------------------
    logic [LW-1:0] len_l;
    logic [LW-1:0] len_eff;
    logic          idx_bad;
    logic          range_empty;
    logic [XW-1:0] lo_x;
    logic [XW-1:0] hi_x;
    logic          accept;
    logic          load_out;
    logic          issue;

    assign len_l       = LW'(len_reg);
    assign len_eff     = (len_l > MAX_LEN) ? MAX_LEN : len_l;
    assign idx_bad     = (LW'(in_first) >= len_eff) || (LW'(in_last) >= len_eff);
    assign range_empty = in_first > in_last;
    assign lo_x        = XW'(in_first);
    assign hi_x        = XW'(in_last);
    assign accept      = s_tvalid && s_tready;
    assign issue       = (state_reg == ST_RUN);

    // ---------------------------------------------------------------
    // Sequencer: clear pass, walk, drain, result
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        s_tready   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                if (cur_reg == LAST_ADDR) begin
                    cur_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cur_next = cur_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (idx_bad || range_empty) begin
                        state_next = ST_RESULT;
                    end else begin
                        cur_next   = lo_x[AW-1:0];
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (cur_reg == hi_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    cur_next = cur_reg + AW'(1);
                end
            end
            ST_DRAIN: begin
                if (vld_reg == '0) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cur_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
        end
    end

    // ---------------------------------------------------------------
    // Length register
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LEN_RESET;
        end else if (cfg_valid) begin
            len_reg <= cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // Item registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= op_t'(s_tuser);
            hi_reg     <= hi_x[AW-1:0];
            v_reg      <= mod_add(in_operand, '0);
            status_reg <= idx_bad;
        end
    end

    // ---------------------------------------------------------------
    // Memory and multiplier
    // ---------------------------------------------------------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    val_t          ram_wdata;
    val_t          ram_rdata;
    val_t          prod;
    logic          wb_vld;
    logic [AW-1:0] wb_addr;
    val_t          wb_e;
    val_t          wb_val;

    ramsp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cur_reg),
        .rdata (ram_rdata)
    );

    ramsp_modmul u_modmul (
        .aclk (aclk),
        .a    (ram_rdata),
        .b    (v_reg),
        .prod (prod)
    );

    // side band runs alongside the RAM read and the multiplier
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[MUL_LAT-1:0], issue};
        end
    end

    always_ff @(posedge aclk) begin
        addr_pipe_reg[0] <= cur_reg;
        for (int k = 1; k <= MUL_LAT; k++) begin
            addr_pipe_reg[k] <= addr_pipe_reg[k-1];
        end
        e_pipe_reg[0] <= ram_rdata;
        for (int k = 1; k < MUL_LAT; k++) begin
            e_pipe_reg[k] <= e_pipe_reg[k-1];
        end
    end

    assign wb_vld  = vld_reg[MUL_LAT];
    assign wb_addr = addr_pipe_reg[MUL_LAT];
    assign wb_e    = e_pipe_reg[MUL_LAT-1];

    // new element value
    always_comb begin
        unique case (op_reg)
            OP_ADD: wb_val = mod_add(wb_e, v_reg);
            OP_MUL: wb_val = prod;
            OP_SET: wb_val = v_reg;
            OP_SUM: wb_val = wb_e;
        endcase
    end

    // write back, or zero fill during the clear pass
    assign ram_we    = (state_reg == ST_CLEAR) || (wb_vld && (op_reg != OP_SUM));
    assign ram_waddr = (state_reg == ST_CLEAR) ? cur_reg : wb_addr;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : wb_val;

    // range sum accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (accept) begin
            acc_reg <= '0;
        end else if (wb_vld && (op_reg == OP_SUM)) begin
            acc_reg <= mod_add(acc_reg, wb_e);
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_sum_reg    <= acc_reg;
            m_status_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_sum_reg);
    assign m_tuser  = M_TUSER_W'(m_status_reg);

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // no item is taken while write-backs are still in flight
    a_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (vld_reg == '0))
        else $error("item accepted with pipeline busy");

    // write-backs only happen while an item is being walked or drained
    a_wb_state: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_vld |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("write-back outside of an item");

    // every stored value is a reduced residue
    a_wdata_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (ram_wdata < PRIME_V))
        else $error("unreduced value written to store");

    // the running sum stays reduced
    a_acc_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg < PRIME_V)
        else $error("accumulator out of range");

    // a finished item always shows up on the result side
    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_tvalid_reg)
        else $error("result not presented");

endmodule

FILE: tb/tb_range_add_mul_set_sum_mod_prime_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for range_add_mul_set_sum_mod_prime_core.
// Depends on ramsp_pkg and the core RTL; holds its own modular-array predictor.
module tb_range_add_mul_set_sum_mod_prime_core;
    import ramsp_pkg::*;

    localparam int              ENTRIES      = 1024;
    localparam longint unsigned MODULUS      = 64'd1000000007;
    localparam int unsigned     CYCLE_LIMIT  = 3000000;
    localparam int unsigned     HOLD_CYCLES  = 400;
    localparam int unsigned     DRAIN_CYCLES = 1100;
    localparam int unsigned     MAX_REPORTS  = 10;

    typedef struct packed {
        bit [VAL_W-1:0] range_sum;
        bit             status;
    } range_result_t;

    // Clock, reset and DUT ports
    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [LEN_W-1:0]      cfg_data;

    // Predictor state: shadow copy of the element store and length register
    bit [VAL_W-1:0]        shadow_store [ENTRIES];
    bit [LEN_W-1:0]        shadow_length;
    range_result_t         pending_sums [$];

    // Run control and bookkeeping
    bit                    gaps_on;
    bit                    hold_request;
    int unsigned           fail_count;
    int unsigned           items_sent;
    int unsigned           results_checked;
    int unsigned           length_settings;
    int unsigned           cycle_count;

    always #1 aclk = ~aclk;

    range_add_mul_set_sum_mod_prime_core #(
        .MAX_ENTRIES(ENTRIES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    task automatic report_failure(string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("ERROR at %0t: %s", $time, what);
        end
    endtask

    // Apply one range operation to the shadow store and return its result
    function automatic range_result_t apply_range_op(op_t op, bit [IDX_W-1:0] first,
                                                     bit [IDX_W-1:0] last,
                                                     bit [VAL_W-1:0] operand);
        longint unsigned v;
        longint unsigned acc;
        longint unsigned e;
        int unsigned     eff;
        range_result_t   r;
        v   = longint'(operand) % MODULUS;
        acc = 0;
        eff = (shadow_length > ENTRIES) ? ENTRIES : shadow_length;
        r.range_sum = '0;
        r.status    = 1'b0;
        // range check comes first, so a flagged empty range still flags
        if (first >= eff || last >= eff) begin
            r.status = 1'b1;
            return r;
        end
        // an empty range simply skips the loop
        for (int k = first; k <= last; k++) begin
            e = longint'(shadow_store[k]);
            case (op)
                OP_ADD: shadow_store[k] = VAL_W'((e + v) % MODULUS);
                OP_MUL: shadow_store[k] = VAL_W'((e * v) % MODULUS);
                OP_SET: shadow_store[k] = VAL_W'(v);
                default: acc = (acc + e) % MODULUS;
            endcase
        end
        if (op == OP_SUM) begin
            r.range_sum = VAL_W'(acc);
        end
        return r;
    endfunction

    // Offer one item, wait for the transfer, then record its expected result
    task automatic send_item(op_t op, bit [IDX_W-1:0] first, bit [IDX_W-1:0] last,
                             bit [VAL_W-1:0] operand);
        int unsigned gap;
        if (gaps_on && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, operand, last, first};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_sums.push_back(apply_range_op(op, first, last, operand));
        items_sent++;
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge aclk);
    endtask

    task automatic write_length(bit [LEN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        shadow_length = value;
        length_settings++;
    endtask

    function automatic bit [VAL_W-1:0] random_operand();
        case ($urandom_range(0, 9))
            0:       return VAL_W'(MODULUS - 1);
            1:       return {VAL_W{1'b1}};
            2:       return VAL_W'($urandom_range(0, 3));
            3:       return VAL_W'(MODULUS + $urandom_range(0, 73741816));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // One random item against the current length: mostly in range, some
    // flagged, some empty ranges; spans kept short with rare full sweeps
    task automatic send_random_item();
        int unsigned    eff;
        int unsigned    kind;
        int unsigned    span;
        int unsigned    bad;
        int unsigned    other;
        bit [IDX_W-1:0] first;
        bit [IDX_W-1:0] last;
        op_t            op;
        eff  = (shadow_length > ENTRIES) ? ENTRIES : shadow_length;
        kind = $urandom_range(0, 99);
        op   = op_t'($urandom_range(0, 3));
        if (eff == 0 || (kind < 10 && eff < ENTRIES)) begin
            bad   = $urandom_range(eff, ENTRIES - 1);
            other = $urandom_range(0, ENTRIES - 1);
            case ($urandom_range(0, 2))
                0:       begin first = IDX_W'(bad);   last = IDX_W'(other); end
                1:       begin first = IDX_W'(other); last = IDX_W'(bad);   end
                default: begin
                    first = IDX_W'(bad);
                    last  = IDX_W'($urandom_range(eff, ENTRIES - 1));
                end
            endcase
        end else if (kind < 20 && eff >= 2) begin
            last  = IDX_W'($urandom_range(0, eff - 2));
            first = IDX_W'($urandom_range(last + 1, eff - 1));
        end else begin
            kind = $urandom_range(0, 99);
            if (kind < 95) begin
                span  = (kind < 80) ? $urandom_range(0, 15) : $urandom_range(16, 200);
                first = IDX_W'($urandom_range(0, eff - 1));
                last  = IDX_W'((first + span > eff - 1) ? eff - 1 : first + span);
            end else begin
                first = '0;
                last  = IDX_W'(eff - 1);
            end
        end
        send_item(op, first, last, random_operand());
    endtask

    // The store must read back as all zeros once the clearing pass is done
    task automatic test_clear_after_reset();
        send_item(OP_SUM, 10'd0, 10'd1023, '0);
        drain_results();
    endtask

    // Every opcode, operand extremes, full-range sweeps and empty ranges
    task automatic test_directed_ops();
        send_item(OP_SET, 10'd0, 10'd0, VAL_W'(MODULUS - 1));
        send_item(OP_SET, 10'd1023, 10'd1023, {VAL_W{1'b1}});
        send_item(OP_ADD, 10'd0, 10'd1023, VAL_W'(MODULUS));
        send_item(OP_ADD, 10'd0, 10'd1023, 30'd5);
        send_item(OP_MUL, 10'd0, 10'd1023, {VAL_W{1'b1}});
        send_item(OP_MUL, 10'd511, 10'd512, 30'd0);
        send_item(OP_SUM, 10'd0, 10'd1023, {VAL_W{1'b1}});
        send_item(OP_SUM, 10'd1023, 10'd1023, '0);
        send_item(OP_SUM, 10'd0, 10'd0, '0);
        send_item(OP_ADD, 10'd10, 10'd9, 30'd7);
        send_item(OP_SUM, 10'd1023, 10'd0, '0);
        drain_results();
    endtask

    // Zero length, unit length, an over-range register value, then back
    task automatic test_length_edges();
        write_length(11'd0);
        send_item(OP_SUM, 10'd0, 10'd0, '0);
        send_item(OP_SET, 10'd0, 10'd0, 30'd1);
        drain_results();
        write_length(11'd1);
        send_item(OP_SET, 10'd0, 10'd0, 30'd123456789);
        send_item(OP_SUM, 10'd0, 10'd0, '0);
        send_item(OP_SUM, 10'd0, 10'd1, '0);
        send_item(OP_SUM, 10'd1, 10'd0, '0);
        drain_results();
        write_length(11'd2047);
        send_item(OP_SUM, 10'd1023, 10'd1023, '0);
        send_item(OP_MUL, 10'd0, 10'd1023, 30'd3);
        drain_results();
        write_length(LEN_RESET);
    endtask

    // Receiver holds off for a long stretch while items keep coming
    task automatic test_output_backpressure();
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        repeat (8) begin
            send_item(op_t'($urandom_range(0, 3)), 10'd100,
                      IDX_W'(10'd100 + $urandom_range(0, 4)), random_operand());
        end
        drain_results();
        gaps_on = 1'b1;
    endtask

    // Phases at several lengths, each of nonzero length loading the array by single-index sets
    // before mixed random traffic; one phase runs with no idling at all
    task automatic test_random_phases();
        bit [LEN_W-1:0] lengths [8];
        int unsigned    count;
        int unsigned    loads;
        lengths = '{11'd1024, 11'd64, 11'd2047, 11'd1, 11'd300, 11'd0, 11'd2, 11'd1024};
        lengths[6] = LEN_W'($urandom_range(2, 1023));
        for (int p = 0; p < 8; p++) begin
            write_length(lengths[p]);
            gaps_on = (p != 2);
            count   = (lengths[p] <= 1) ? 30 : 86;
            loads   = (lengths[p] < 16) ? lengths[p] : 16;
            for (int i = 0; i < loads; i++) begin
                send_item(OP_SET, IDX_W'(i), IDX_W'(i), random_operand());
            end
            repeat (count - loads) send_random_item();
            drain_results();
        end
        gaps_on = 1'b1;
    endtask

    // Result checker: every result transfer against the oldest expectation
    always @(posedge aclk) begin
        range_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_sums.size() == 0) begin
                report_failure($sformatf("unexpected result sum=%0d status=%0d",
                                         m_tdata[VAL_W-1:0], m_tuser[0]));
            end else begin
                want = pending_sums.pop_front();
                results_checked++;
                if (m_tdata[VAL_W-1:0] !== want.range_sum) begin
                    report_failure($sformatf("range_sum expected %0d actual %0d",
                                             want.range_sum, m_tdata[VAL_W-1:0]));
                end
                if (m_tuser[0] !== want.status) begin
                    report_failure($sformatf("status expected %0d actual %0d",
                                             want.status, m_tuser[0]));
                end
            end
        end
    end

    // Result-side ready: random idling, or a counted hold-off on request
    initial begin : result_sink
        int unsigned held;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge aclk);
                hold_request = 1'b0;
            end else if (gaps_on && $urandom_range(0, 99) < 25) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("range_add_mul_set_sum_mod_prime_core verification failed");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        gaps_on      = 1'b1;
        hold_request = 1'b0;
        fail_count      = 0;
        items_sent      = 0;
        results_checked = 0;
        length_settings = 0;
        foreach (shadow_store[k]) shadow_store[k] = '0;
        shadow_length = LEN_RESET;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_clear_after_reset();
        test_directed_ops();
        test_length_edges();
        test_output_backpressure();
        test_random_phases();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_sums.size() != 0) begin
            report_failure($sformatf("%0d results never arrived", pending_sums.size()));
        end

        $display("Sent %0d range items, checked %0d results over %0d length settings,",
                 items_sent, results_checked, length_settings);
        $display("with a long output hold-off; %0d failures seen", fail_count);
        if (fail_count == 0) begin
            $display("range_add_mul_set_sum_mod_prime_core verification clean");
        end else begin
            $display("range_add_mul_set_sum_mod_prime_core verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/ramsp_pkg.sv
rtl/ramsp_ram.sv
rtl/ramsp_modmul.sv
rtl/range_add_mul_set_sum_mod_prime_core.sv
tb/tb_range_add_mul_set_sum_mod_prime_core.sv
